// ===== hdl/lru_page_replacement_top_assert.svh =====
// Assertion macros for the LRU page replacement block.
// Used by the port-level checker; no other dependencies.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define LRU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lru assertion failed");

// Next-cycle implication, masked while reset is held.
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lru assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define LRU_ASSERT_NEXT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lru assertion failed");

`endif

// ===== hdl/lru_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
// No dependencies.
`default_nettype none

package lru_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;
  localparam int CFG_W         = 4;
  localparam int FAULT_W       = 32;

  localparam logic [CFG_W-1:0] NUM_FRAMES_RST = 4'd8;

  // Status a cell hands to the top level and to its newer neighbor.
  typedef struct packed {
    logic match;
    logic shift;
  } cell_link_t;

endpackage

`default_nettype wire

// ===== hdl/lru_ifs.sv =====
// Valid/ready channel interfaces for page references and results.
// Depends on lru_pkg for default widths.
`default_nettype none

interface lru_req_if #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lru_rsp_if #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) ();
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic                        valid;
  logic                        ready;
  logic                        fault;
  logic                        evicted_valid;
  logic [PAGE_BITS-1:0]        evicted_page;
  logic [lru_pkg::FAULT_W-1:0] fault_total;
  logic [CNT_W-1:0]            resident_count;

  modport source (output valid, output fault, output evicted_valid, output evicted_page,
                  output fault_total, output resident_count, input ready);
  modport sink   (input valid, input fault, input evicted_valid, input evicted_page,
                  input fault_total, input resident_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/lru_cell.sv =====
// One frame of the recency chain: holds a page, compares, and shifts.
// Depends on lru_pkg for the link struct.
`default_nettype none

module lru_cell #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  parameter int CNT_W     = 4,
  parameter int IDX       = 0
) (
  input  wire logic                clk,
  input  wire logic                en_i,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic [PAGE_BITS-1:0] nbr_page_i,
  input  wire logic [CNT_W-1:0]    occ_i,
  input  wire logic [CNT_W-1:0]    tail_i,
  input  wire logic                shift_i,
  output lru_pkg::cell_link_t      link_o,
  output logic [PAGE_BITS-1:0]     page_o
);
  import lru_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;
  logic                 in_use;

  assign in_use       = IDX_C < occ_i;
  assign link_o.match = in_use && (page_r == page_i);
  // Everything from the hit position (or the whole list on eviction) advances.
  assign link_o.shift = shift_i || link_o.match;
  assign page_o       = page_r;

  always_comb begin
    page_nxt = page_r;
    if (en_i) begin
      if (IDX_C == tail_i) begin
        page_nxt = page_i;
      end else if ((IDX_C < tail_i) && link_o.shift) begin
        page_nxt = nbr_page_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: chain of frame cells,
// occupancy, fault counter and result register. Depends on lru_pkg,
// lru_ifs and lru_cell.
//
// Usage:
//   in_ch  carries one page reference per transaction (valid/ready).
//   out_ch returns exactly one result per reference: fault, evicted page,
//          running fault total (saturating) and frames occupied afterward.
//   cfg_we/cfg_wdata write num_frames; write only while no reference is
//          in flight. 0 acts as 1, values above FRAMES act as FRAMES.
// Result: registered; it appears in the cycle after its reference is accepted.
// Throughput: one reference per cycle while no held result stalls input; the
//   full compare-and-shift of all FRAMES cells is combinational and lands at
//   the accepting edge, so the next reference sees the updated recency order.
// Stall: a held result blocks new references until out_ch.ready takes it;
//   in_ch.ready rises in the same cycle the result is taken.
// Reset: synchronous, active low. Occupancy and fault count clear, the
//   frame limit returns to 8, no result is pending. Frame contents are not
//   cleared; only occupied frames are ever compared or reported.
`default_nettype none

module lru_page_replacement_top #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  lru_req_if.sink                        in_ch,
  lru_rsp_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [lru_pkg::CFG_W-1:0] cfg_wdata
);
  import lru_pkg::*;

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Configuration and state
  logic [CFG_W-1:0]   num_frames_r;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [FAULT_W-1:0] fault_cnt_r, fault_cnt_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 fault_r, fault_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [PAGE_BITS-1:0] ev_page_r, ev_page_nxt;

  // Cell chain
  logic [PAGE_BITS-1:0] cell_page [FRAMES];
  cell_link_t           link [FRAMES];
  logic [FRAMES-1:0]    match_vec;

  logic             accept;
  logic             hit;
  logic             full_miss;
  logic [LIM_W-1:0] nf_ext, lim_ext;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] tail;

  // Accept whenever the result slot is empty or being drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the frame limit into 1..FRAMES.
  always_comb begin
    nf_ext  = LIM_W'(num_frames_r);
    lim_ext = (nf_ext == '0) ? LIM_W'(1) : nf_ext;
    if (lim_ext > LIM_W'(FRAMES)) begin
      lim_ext = LIM_W'(FRAMES);
    end
    lim = CNT_W'(lim_ext);
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    assign match_vec[k] = link[k].match;

    lru_cell #(
      .PAGE_BITS (PAGE_BITS),
      .CNT_W     (CNT_W),
      .IDX       (k)
    ) u_cell (
      .clk        (clk),
      .en_i       (accept),
      .page_i     (in_ch.page),
      .nbr_page_i ((k == FRAMES - 1) ? cell_page[k] : cell_page[(k + 1) % FRAMES]),
      .occ_i      (occ_r),
      .tail_i     (tail),
      .shift_i    ((k == 0) ? full_miss : link[(k + FRAMES - 1) % FRAMES].shift),
      .link_o     (link[k]),
      .page_o     (cell_page[k])
    );
  end

  assign hit       = |match_vec;
  assign full_miss = !hit && (occ_r >= lim);
  // New page lands at the newest slot; it grows only when a frame is free.
  assign tail      = (hit || full_miss) ? (occ_r - CNT_W'(1)) : occ_r;

  always_comb begin
    occ_nxt       = occ_r;
    fault_cnt_nxt = fault_cnt_r;
    fault_nxt     = fault_r;
    ev_valid_nxt  = ev_valid_r;
    ev_page_nxt   = ev_page_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      fault_nxt     = !hit;
      ev_valid_nxt  = full_miss;
      ev_page_nxt   = full_miss ? cell_page[0] : '0;
      if (!hit && !full_miss) begin
        occ_nxt = occ_r + CNT_W'(1);
      end
      // Hold the counter at its maximum.
      if (!hit && (fault_cnt_r != '1)) begin
        fault_cnt_nxt = fault_cnt_r + FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= NUM_FRAMES_RST;
      occ_r        <= '0;
      fault_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_frames_r <= cfg_wdata;
      end
      occ_r       <= occ_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fault_r    <= fault_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_page_r  <= ev_page_nxt;
  end

  // Counter and occupancy change only on accept, so they stay valid as
  // result fields while the transaction waits.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.fault          = fault_r;
  assign out_ch.evicted_valid  = ev_valid_r;
  assign out_ch.evicted_page   = ev_page_r;
  assign out_ch.fault_total    = fault_cnt_r;
  assign out_ch.resident_count = occ_r;

endmodule

`default_nettype wire

// ===== hdl/lru_chk.sv =====
// Port-level checker for the LRU page replacement block, bound to the top.
// Depends on lru_pkg and lru_page_replacement_top_assert.svh.
`default_nettype none

`include "lru_page_replacement_top_assert.svh"

module lru_chk #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  parameter int CNT_W     = 4
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_fault,
  input wire logic                 out_evicted_valid,
  input wire logic [PAGE_BITS-1:0] out_evicted_page,
  input wire logic [CNT_W-1:0]     out_resident_count
);
  import lru_pkg::*;

  localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);

  `LRU_ASSERT_NEXT_RAW(a_reset_clears, clk, !rst_n, !out_valid)
  `LRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `LRU_ASSERT_IMPLY(a_evict_needs_fault, clk, rst_n, out_valid && out_evicted_valid, out_fault)
  `LRU_ASSERT_IMPLY(a_evict_page_zero, clk, rst_n, out_valid && !out_evicted_valid, out_evicted_page == '0)
  `LRU_ASSERT_IMPLY(a_occ_range, clk, rst_n, out_valid, (out_resident_count != '0) && (out_resident_count <= FRAMES_C))

endmodule

bind lru_page_replacement_top lru_chk #(
  .FRAMES    (FRAMES),
  .PAGE_BITS (PAGE_BITS),
  .CNT_W     ($clog2(FRAMES + 1))
) u_lru_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_fault          (out_ch.fault),
  .out_evicted_valid  (out_ch.evicted_valid),
  .out_evicted_page   (out_ch.evicted_page),
  .out_resident_count (out_ch.resident_count)
);

`default_nettype wire

// ===== tb/lru_tb_pkg.sv =====
// Result prediction and checking for the LRU page replacement testbench.
// Depends on lru_pkg for widths and the reset frame limit.
package lru_tb_pkg;
  import lru_pkg::*;

  localparam int NFRAMES = FRAMES_DEF;
  localparam int PB      = PAGE_BITS_DEF;
  localparam int CNT_W   = $clog2(NFRAMES + 1);

  typedef logic [PB-1:0] page_t;

  typedef struct packed {
    logic               fault;
    logic               evicted_valid;
    page_t              evicted_page;
    logic [FAULT_W-1:0] fault_total;
    logic [CNT_W-1:0]   resident_count;
  } lru_outcome_t;

  class lru_recency_checker;
    page_t              resident_pages[$];  // front is least recently used
    logic [CFG_W-1:0]   frames_reg;
    logic [FAULT_W-1:0] fault_count;
    lru_outcome_t       pending_outcomes[$];
    int unsigned        mismatches;

    function new();
      frames_reg  = NUM_FRAMES_RST;
      fault_count = '0;
      mismatches  = 0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] value);
      frames_reg = value;
    endfunction

    // Zero acts as one frame, anything above the built count as the full set.
    function int unsigned frame_limit();
      if (frames_reg == 0) return 1;
      if (frames_reg > NFRAMES) return NFRAMES;
      return frames_reg;
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction

    // Update the recency order for one accepted reference and queue its outcome.
    function void note_reference(page_t page);
      lru_outcome_t outcome;
      int           hit_at;
      hit_at  = -1;
      outcome = '0;
      foreach (resident_pages[i])
        if (hit_at < 0 && resident_pages[i] == page) hit_at = i;
      if (hit_at >= 0) begin
        resident_pages.delete(hit_at);
      end else begin
        outcome.fault = 1'b1;
        if (fault_count != '1) fault_count++;
        // A lowered limit never shrinks occupancy: a miss at or above it swaps one page.
        if (resident_pages.size() >= frame_limit()) begin
          outcome.evicted_valid = 1'b1;
          outcome.evicted_page  = resident_pages.pop_front();
        end
      end
      resident_pages.insert(resident_pages.size(), page);
      outcome.fault_total    = fault_count;
      outcome.resident_count = CNT_W'(resident_pages.size());
      pending_outcomes.insert(pending_outcomes.size(), outcome);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("ERROR @%0t: %s", $time, what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_result(lru_outcome_t got);
      lru_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("unexpected result 0x%0h with nothing outstanding", got));
        return;
      end
      want = pending_outcomes.pop_front();
      check_field("fault", got.fault, want.fault);
      check_field("evicted_valid", got.evicted_valid, want.evicted_valid);
      check_field("evicted_page", got.evicted_page, want.evicted_page);
      check_field("fault_total", got.fault_total, want.fault_total);
      check_field("resident_count", got.resident_count, want.resident_count);
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for lru_page_replacement_top: directed and random page
// references under bursty input and stalling output, checked per result.
// Depends on lru_pkg, lru_ifs and lru_tb_pkg.
module tb_top;
  import lru_pkg::*;
  import lru_tb_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_e;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lru_req_if in_ch ();
  lru_rsp_if out_ch ();

  lru_page_replacement_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lru_recency_checker recency_book = new();

  // Sender state: burst bookkeeping and the working set for the current phase.
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  page_t       hot_pages[$];

  // Receiver state: its own cycle count, pattern and long hold-off counter.
  int unsigned rx_cycle     = 0;
  rx_pattern_e rx_pattern   = RX_OPEN;
  int unsigned pattern_left = 0;
  int unsigned hold_left    = 0;

  // Opening references at the default limit of 8: extremes, alternating bit
  // patterns, a hit on the oldest page, a full set, then evictions and hits that
  // reorder the most recent end.
  page_t warm_pages[$] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0000,
                           16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
                           16'hFFFF, 16'h0004, 16'h5555, 16'h8000};

  // Limits for the random phases: extremes, out-of-range values and a drop
  // from 8 to 2 while all frames are occupied.
  logic [CFG_W-1:0] phase_frames[$] = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd4,
                                        4'd9, 4'd6, 4'd3, 4'd8, 4'd5, 4'd7};

  always #5 clk = ~clk;

  // Receiver: check every result taken, then choose ready for the next edge.
  always @(posedge clk) begin
    lru_outcome_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.fault          = out_ch.fault;
        got.evicted_valid  = out_ch.evicted_valid;
        got.evicted_page   = out_ch.evicted_page;
        got.fault_total    = out_ch.fault_total;
        got.resident_count = out_ch.resident_count;
        recency_book.check_result(got);
      end
      rx_cycle++;
      if (hold_left > 0) begin
        // Hold off while the sender keeps offering so the block backs up.
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_cycle % 1500 == 700) begin
        hold_left = $urandom_range(40, 70);
        out_ch.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          rx_pattern   = rx_pattern_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        case (rx_pattern)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= rx_cycle[0];
        endcase
      end
    end
  end

  // Offer one page and hold it until the block takes the transaction.
  // Start a new burst with a random gap unless the phase runs steady.
  task automatic offer(input page_t page);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.page  <= page;
    do @(posedge clk); while (!in_ch.ready);
    recency_book.note_reference(page);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (recency_book.outstanding() != 0) @(posedge clk);
  endtask

  // Write the frame limit once the block is idle.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    recency_book.set_frames(value);
  endtask

  // Mostly reuse the phase working set to get hits and LRU evictions;
  // otherwise pick any page.
  function automatic page_t pick_page();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return hot_pages[$urandom_range(0, hot_pages.size() - 1)];
    return page_t'($urandom);
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] frames, input int unsigned count);
    int unsigned set_size;
    write_frames(frames);
    set_size = recency_book.frame_limit() + $urandom_range(0, 3);
    hot_pages.delete();
    repeat (set_size) hot_pages.insert(hot_pages.size(), page_t'($urandom));
    steady = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      // Pause the sender halfway until everything has come back.
      if (i == count / 2) drain();
      offer(pick_page());
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.page  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warm_pages[i]) offer(warm_pages[i]);

    // Drop the limit to one frame with eight occupied: misses swap the
    // oldest page, hits still find any resident page.
    write_frames(4'd0);
    offer(16'h1234);
    offer(16'h0005);
    offer(16'h0001);

    // Raise past the built count: acts as the full set.
    write_frames(4'd15);
    offer(16'h7FFF);
    offer(16'h0000);
    offer(16'h1234);

    foreach (phase_frames[i]) run_phase(phase_frames[i], 85);

    drain();
    repeat (5) @(posedge clk);
    if (recency_book.mismatches == 0 && recency_book.outstanding() == 0) begin
      $display("lru_page_replacement_top: match");
    end else begin
      $display("lru_page_replacement_top: mismatch");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("lru_page_replacement_top: mismatch");
    $finish;
  end

endmodule
